@@ rtl/core/rpi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared types and constants of the ray / plane intersection pipeline.
// ----------------------------------------------------------------------------
package rpi_pkg;

  localparam int COORD_W = 32;
  localparam int NUM_W   = 65;   // |N.(P-O)| < 3 * 2^63
  localparam int DEN_W   = 64;   // |N.D| <= 3 * 2^62
  localparam int SQ_W    = 64;   // |N|^2, |D|^2 <= 3 * 2^62
  localparam int PROD_W  = NUM_W + COORD_W;
  localparam int QUOT_W  = 33;   // quotients at or above 2^33 always saturate

  // 1e10 = 5^10 * 2^10
  localparam int              PAR_MUL_W = 24;
  localparam logic [PAR_MUL_W-1:0] PAR_MUL = 24'd9765625;
  localparam int              PAR_SHIFT = 10;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] ray_origin_x;
    logic signed [COORD_W-1:0] ray_origin_y;
    logic signed [COORD_W-1:0] ray_origin_z;
    logic signed [COORD_W-1:0] ray_dir_x;
    logic signed [COORD_W-1:0] ray_dir_y;
    logic signed [COORD_W-1:0] ray_dir_z;
    logic signed [COORD_W-1:0] plane_point_x;
    logic signed [COORD_W-1:0] plane_point_y;
    logic signed [COORD_W-1:0] plane_point_z;
    logic signed [COORD_W-1:0] plane_normal_x;
    logic signed [COORD_W-1:0] plane_normal_y;
    logic signed [COORD_W-1:0] plane_normal_z;
  } rpi_in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
    logic                      clipped;
  } rpi_out_t;

  // Dot-product front end results, as magnitudes and signs
  typedef struct packed {
    logic [NUM_W-1:0]            num_mag;
    logic                        num_neg;
    logic [DEN_W-1:0]            den_mag;
    logic                        den_neg;
    logic [SQ_W-1:0]             nn;
    logic [SQ_W-1:0]             dd;
    logic                        degen;
    logic [2:0][COORD_W-1:0]     o;
    logic [2:0][COORD_W-1:0]     d_mag;
    logic [2:0]                  d_neg;
  } rpi_dot_t;

endpackage

@@ rtl/core/rpi_mulw.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_mulw
// Pipelined unsigned wide multiplier: one 32-bit digit of a per stage,
// 32x32 partial products accumulated stage by stage.
// ----------------------------------------------------------------------------
module rpi_mulw import rpi_pkg::*; #(
  parameter int WA = 64,
  parameter int WB = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int ND  = (WA + 31) / 32;
  localparam int NB  = (WB + 31) / 32;
  localparam int WAP = ND * 32;
  localparam int WBP = NB * 32;
  localparam int WS  = WAP + WBP;

  logic [WAP-1:0] a_r   [ND];
  logic [WBP-1:0] b_r   [ND];
  logic [WS-1:0]  acc_r [ND];

  for (genvar k = 0; k < ND; k++) begin : g_stage
    logic [WAP-1:0] a_in;
    logic [WBP-1:0] b_in;
    logic [WS-1:0]  acc_in;
    logic [WS-1:0]  acc_nxt;
    logic [63:0]    pp [NB];

    if (k == 0) begin : g_first
      assign a_in   = WAP'(a);
      assign b_in   = WBP'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
    end

    always_comb begin
      acc_nxt = acc_in;
      for (int j = 0; j < NB; j++) begin
        pp[j]   = a_in[32*k +: 32] * b_in[32*j +: 32];
        acc_nxt = acc_nxt + (WS'(pp[j]) << (32 * (k + j)));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k]   <= a_in;
        b_r[k]   <= b_in;
        acc_r[k] <= acc_nxt;
      end
    end
  end

  assign p = acc_r[ND-1][WA+WB-1:0];

endmodule

@@ rtl/core/rpi_dot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_dot
// Front end: exact dot products N.(P-O), N.D, N.N, D.D in three stages
// (products, sums, magnitudes).
// ----------------------------------------------------------------------------
module rpi_dot import rpi_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  rpi_in_t  in_data,
  output rpi_dot_t dot
);

  logic signed [COORD_W-1:0] o_v [3];
  logic signed [COORD_W-1:0] d_v [3];
  logic signed [COORD_W-1:0] p_v [3];
  logic signed [COORD_W-1:0] n_v [3];
  logic signed [COORD_W:0]   diff [3];

  // stage 1
  logic signed [2*COORD_W:0]   pn_nxt [3], pn_r [3];
  logic signed [2*COORD_W-1:0] pd_nxt [3], pd_r [3];
  logic signed [2*COORD_W-1:0] pnn_nxt [3], pnn_r [3];
  logic signed [2*COORD_W-1:0] pdd_nxt [3], pdd_r [3];
  logic signed [COORD_W-1:0]   o1_r [3], d1_r [3];

  // stage 2
  logic signed [NUM_W+1:0]   num_nxt, num_r;
  logic signed [DEN_W+1:0]   den_nxt, den_r;
  logic [SQ_W-1:0]           nn_nxt, nn_r, dd_nxt, dd_r;
  logic signed [COORD_W-1:0] o2_r [3], d2_r [3];

  // stage 3
  rpi_dot_t dot_nxt, dot_r;

  always_comb begin
    o_v[0] = in_data.ray_origin_x;   o_v[1] = in_data.ray_origin_y;
    o_v[2] = in_data.ray_origin_z;
    d_v[0] = in_data.ray_dir_x;      d_v[1] = in_data.ray_dir_y;
    d_v[2] = in_data.ray_dir_z;
    p_v[0] = in_data.plane_point_x;  p_v[1] = in_data.plane_point_y;
    p_v[2] = in_data.plane_point_z;
    n_v[0] = in_data.plane_normal_x; n_v[1] = in_data.plane_normal_y;
    n_v[2] = in_data.plane_normal_z;
    for (int i = 0; i < 3; i++) begin
      diff[i]    = (COORD_W+1)'(p_v[i]) - (COORD_W+1)'(o_v[i]);
      pn_nxt[i]  = n_v[i] * diff[i];
      pd_nxt[i]  = n_v[i] * d_v[i];
      pnn_nxt[i] = n_v[i] * n_v[i];
      pdd_nxt[i] = d_v[i] * d_v[i];
    end
  end

  always_comb begin
    num_nxt = (NUM_W+2)'(pn_r[0]) + (NUM_W+2)'(pn_r[1]) + (NUM_W+2)'(pn_r[2]);
    den_nxt = (DEN_W+2)'(pd_r[0]) + (DEN_W+2)'(pd_r[1]) + (DEN_W+2)'(pd_r[2]);
    // squares are never negative and their sum stays below 2^64
    nn_nxt  = $unsigned(pnn_r[0]) + $unsigned(pnn_r[1]) + $unsigned(pnn_r[2]);
    dd_nxt  = $unsigned(pdd_r[0]) + $unsigned(pdd_r[1]) + $unsigned(pdd_r[2]);
  end

  always_comb begin
    logic signed [NUM_W+1:0] num_abs;
    logic signed [DEN_W+1:0] den_abs;
    num_abs         = num_r[NUM_W+1] ? -num_r : num_r;
    den_abs         = den_r[DEN_W+1] ? -den_r : den_r;
    dot_nxt.num_mag = num_abs[NUM_W-1:0];
    dot_nxt.num_neg = num_r[NUM_W+1];
    dot_nxt.den_mag = den_abs[DEN_W-1:0];
    dot_nxt.den_neg = den_r[DEN_W+1];
    dot_nxt.nn      = nn_r;
    dot_nxt.dd      = dd_r;
    dot_nxt.degen   = (nn_r == '0) || (dd_r == '0);
    for (int i = 0; i < 3; i++) begin
      dot_nxt.o[i]     = o2_r[i];
      dot_nxt.d_neg[i] = d2_r[i][COORD_W-1];
      // -(-2^31) wraps to 0x80000000, which is right as an unsigned magnitude
      dot_nxt.d_mag[i] = d2_r[i][COORD_W-1] ? (~d2_r[i] + 1'b1) : d2_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pn_r[i]  <= pn_nxt[i];
        pd_r[i]  <= pd_nxt[i];
        pnn_r[i] <= pnn_nxt[i];
        pdd_r[i] <= pdd_nxt[i];
        o1_r[i]  <= o_v[i];
        d1_r[i]  <= d_v[i];
        o2_r[i]  <= o1_r[i];
        d2_r[i]  <= d1_r[i];
      end
      num_r <= num_nxt;
      den_r <= den_nxt;
      nn_r  <= nn_nxt;
      dd_r  <= dd_nxt;
      dot_r <= dot_nxt;
    end
  end

  assign dot = dot_r;

endmodule

@@ rtl/core/rpi_coord.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_coord
// One coordinate: rounded quotient |D*num| / |den| by a restoring divider,
// one quotient bit per stage, then add to the origin and saturate.
// ----------------------------------------------------------------------------
module rpi_coord import rpi_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic [PROD_W-1:0]         prod,
  input  logic [DEN_W-1:0]          den_mag,
  input  logic                      neg,
  input  logic signed [COORD_W-1:0] o,
  output logic signed [COORD_W-1:0] coord,
  output logic                      clip
);

  localparam int XW  = PROD_W + 1;   // 2a + b
  localparam int YW  = DEN_W + 1;    // 2b
  localparam int NST = QUOT_W + 1;

  logic [YW-1:0]             rem_r [NST], rem_nxt [NST];
  logic [QUOT_W-1:0]         low_r [NST], low_nxt [NST];
  logic [QUOT_W-1:0]         q_r   [NST], q_nxt   [NST];
  logic [YW-1:0]             y_r   [NST], y_nxt   [NST];
  logic                      ovf_r [NST], ovf_nxt [NST];
  logic                      neg_r [NST], neg_nxt [NST];
  logic signed [COORD_W-1:0] o_r   [NST], o_nxt   [NST];

  logic signed [COORD_W-1:0] coord_nxt, coord_r;
  logic                      clip_nxt, clip_r;

  // round to nearest, ties away: q = floor((2a + b) / 2b)
  always_comb begin
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    x          = {prod, 1'b0} + XW'(den_mag);
    y          = {den_mag, 1'b0};
    rem_nxt[0] = x[XW-1:QUOT_W];
    low_nxt[0] = x[QUOT_W-1:0];
    q_nxt[0]   = '0;
    y_nxt[0]   = y;
    ovf_nxt[0] = x[XW-1:QUOT_W] >= y;   // quotient would reach 2^33
    neg_nxt[0] = neg;
    o_nxt[0]   = o;

    for (int k = 0; k < QUOT_W; k++) begin
      logic [YW:0] t;
      logic        ge;
      t            = {rem_r[k], low_r[k][QUOT_W-1]};
      ge           = t >= {1'b0, y_r[k]};
      rem_nxt[k+1] = ge ? YW'(t - {1'b0, y_r[k]}) : YW'(t);
      low_nxt[k+1] = {low_r[k][QUOT_W-2:0], 1'b0};
      q_nxt[k+1]   = {q_r[k][QUOT_W-2:0], ge};
      y_nxt[k+1]   = y_r[k];
      ovf_nxt[k+1] = ovf_r[k];
      neg_nxt[k+1] = neg_r[k];
      o_nxt[k+1]   = o_r[k];
    end
  end

  always_comb begin
    logic signed [QUOT_W+1:0] sq;
    logic signed [QUOT_W+1:0] s;
    sq = neg_r[NST-1] ? -$signed((QUOT_W+2)'(q_r[NST-1]))
                      : $signed((QUOT_W+2)'(q_r[NST-1]));
    s  = (QUOT_W+2)'(o_r[NST-1]) + sq;
    if (ovf_r[NST-1]) begin
      coord_nxt = neg_r[NST-1] ? COORD_MIN : COORD_MAX;
      clip_nxt  = 1'b1;
    end else if (s > (QUOT_W+2)'(COORD_MAX)) begin
      coord_nxt = COORD_MAX;
      clip_nxt  = 1'b1;
    end else if (s < (QUOT_W+2)'(COORD_MIN)) begin
      coord_nxt = COORD_MIN;
      clip_nxt  = 1'b1;
    end else begin
      coord_nxt = s[COORD_W-1:0];
      clip_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        q_r[k]   <= q_nxt[k];
        y_r[k]   <= y_nxt[k];
        ovf_r[k] <= ovf_nxt[k];
        neg_r[k] <= neg_nxt[k];
        o_r[k]   <= o_nxt[k];
      end
      coord_r <= coord_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign coord = coord_r;
  assign clip  = clip_r;

endmodule

@@ rtl/core/ray_plane_intersection_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_plane_intersection_unit
// Ray / plane intersection in signed Q16.16, exact products, rounded divide.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every cycle while in_stall is
// low. The pipeline depth is set by the per-coordinate restoring divider
// (one quotient bit per stage, 33 bits plus setup and saturation) behind a
// three-stage dot-product front end and a three-stage wide multiplier. All
// stages advance together; while a result waits at the output under stall,
// the whole pipeline holds and in_stall is raised. Parallel or degenerate
// rays return hit = 0 with all other fields 0.
// ----------------------------------------------------------------------------
module ray_plane_intersection_unit import rpi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rpi_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rpi_out_t out_data
);

  localparam int CORE_LAT = 41;  // stage 1 .. stage 41 before output register
  localparam int HIT_LAT  = 32;  // stage 10 .. stage 41

  logic     en;
  logic     vld_r [CORE_LAT];
  logic     out_valid_r;
  rpi_out_t out_data_r, out_data_nxt;

  rpi_dot_t dot;

  logic [2*DEN_W-1:0]           den2;
  logic [2*SQ_W-1:0]            nd;
  logic [2*DEN_W+PAR_MUL_W-1:0] den2c;
  logic [2*SQ_W-1:0]            nd_dly_r [4];
  logic                         degen_dly_r [6];
  logic                         hit_r [HIT_LAT];
  logic                         hit_nxt;

  logic [DEN_W-1:0]          den_dly_r [3];
  logic [2:0]                neg_dly_r [3];
  logic [2:0][COORD_W-1:0]   o_dly_r [3];
  logic [PROD_W-1:0]         prod [3];
  logic signed [COORD_W-1:0] coord [3];
  logic                      clip [3];

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  rpi_dot u_dot (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .dot     (dot)
  );

  // parallel test: den^2 * 5^10 * 2^10 < nn * dd
  rpi_mulw #(.WA(DEN_W), .WB(DEN_W)) u_den2 (
    .clk (clk), .en (en), .a (dot.den_mag), .b (dot.den_mag), .p (den2)
  );

  rpi_mulw #(.WA(SQ_W), .WB(SQ_W)) u_nd (
    .clk (clk), .en (en), .a (dot.nn), .b (dot.dd), .p (nd)
  );

  rpi_mulw #(.WA(2*DEN_W), .WB(PAR_MUL_W)) u_den2c (
    .clk (clk), .en (en), .a (den2), .b (PAR_MUL), .p (den2c)
  );

  always_comb begin
    logic [2*DEN_W+PAR_MUL_W+PAR_SHIFT-1:0] lhs;
    logic [2*DEN_W+PAR_MUL_W+PAR_SHIFT-1:0] rhs;
    lhs     = {den2c, {PAR_SHIFT{1'b0}}};
    rhs     = (2*DEN_W+PAR_MUL_W+PAR_SHIFT)'(nd_dly_r[3]);
    hit_nxt = !degen_dly_r[5] && !(lhs < rhs);
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    rpi_mulw #(.WA(NUM_W), .WB(COORD_W)) u_prod (
      .clk (clk), .en (en), .a (dot.num_mag), .b (dot.d_mag[i]), .p (prod[i])
    );

    rpi_coord u_coord (
      .clk     (clk),
      .en      (en),
      .prod    (prod[i]),
      .den_mag (den_dly_r[2]),
      .neg     (neg_dly_r[2][i]),
      .o       (o_dly_r[2][i]),
      .coord   (coord[i]),
      .clip    (clip[i])
    );
  end

  always_comb begin
    logic h;
    h                    = hit_r[HIT_LAT-1];
    out_data_nxt.hit     = h;
    out_data_nxt.hit_x   = h ? coord[0] : '0;
    out_data_nxt.hit_y   = h ? coord[1] : '0;
    out_data_nxt.hit_z   = h ? coord[2] : '0;
    out_data_nxt.clipped = h && (clip[0] || clip[1] || clip[2]);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CORE_LAT; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < CORE_LAT; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[CORE_LAT-1];
    end
  end

  // payload delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      nd_dly_r[0] <= nd;
      for (int k = 1; k < 4; k++) nd_dly_r[k] <= nd_dly_r[k-1];
      degen_dly_r[0] <= dot.degen;
      for (int k = 1; k < 6; k++) degen_dly_r[k] <= degen_dly_r[k-1];
      hit_r[0] <= hit_nxt;
      for (int k = 1; k < HIT_LAT; k++) hit_r[k] <= hit_r[k-1];

      den_dly_r[0] <= dot.den_mag;
      neg_dly_r[0] <= dot.d_neg ^ {3{dot.num_neg ^ dot.den_neg}};
      o_dly_r[0]   <= dot.o;
      for (int k = 1; k < 3; k++) begin
        den_dly_r[k] <= den_dly_r[k-1];
        neg_dly_r[k] <= neg_dly_r[k-1];
        o_dly_r[k]   <= o_dly_r[k-1];
      end

      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/ray_plane_intersection_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_plane_intersection_unit_test
// Ray / plane intersection check against an exact wide-integer predictor.
// Directed corner rays, then random rays under varying idle and stall,
// including a long output hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module ray_plane_intersection_unit_test;
  import rpi_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LATENCY = 41;

  typedef logic signed [191:0] wide_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rpi_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rpi_out_t out_data;

  rpi_in_t  pending_rays[$];
  rpi_out_t expected_hits[$];
  int       error_count;
  int       idle_cycles;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_cycles;
  bit       stim_done;
  bit       in_taken;

  ray_plane_intersection_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Exact intersection: all sums and products in 192 bits, one rounding step.
  function automatic rpi_out_t intersect_ray(rpi_in_t r);
    wide_t o[3], d[3], p[3], n[3];
    wide_t num, den, nn, dd, prod, a, b, q, s;
    rpi_out_t res;
    o[0] = r.ray_origin_x;   o[1] = r.ray_origin_y;   o[2] = r.ray_origin_z;
    d[0] = r.ray_dir_x;      d[1] = r.ray_dir_y;      d[2] = r.ray_dir_z;
    p[0] = r.plane_point_x;  p[1] = r.plane_point_y;  p[2] = r.plane_point_z;
    n[0] = r.plane_normal_x; n[1] = r.plane_normal_y; n[2] = r.plane_normal_z;
    num = 0; den = 0; nn = 0; dd = 0;
    for (int i = 0; i < 3; i++) begin
      num += n[i] * (p[i] - o[i]);
      den += n[i] * d[i];
      nn  += n[i] * n[i];
      dd  += d[i] * d[i];
    end
    res = '0;
    if (nn == 0 || dd == 0) return res;
    // both sides stay below 2^170, so signed compare is safe
    if (den * den * 64'sd10000000000 < nn * dd) return res;
    b = (den < 0) ? -den : den;
    for (int i = 0; i < 3; i++) begin
      prod = d[i] * num;
      a = (prod < 0) ? -prod : prod;
      q = (2 * a + b) / (2 * b);
      if ((prod < 0) != (den < 0)) q = -q;
      s = o[i] + q;
      if (s > 64'sd2147483647) begin
        s = COORD_MAX; res.clipped = 1'b1;
      end else if (s < -64'sd2147483648) begin
        s = COORD_MIN; res.clipped = 1'b1;
      end
      case (i)
        0: res.hit_x = s[31:0];
        1: res.hit_y = s[31:0];
        default: res.hit_z = s[31:0];
      endcase
    end
    res.hit = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
      default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endcase
  endfunction

  // Mostly moderate rays that hit in range, some wild ones and near-parallel ones.
  function automatic rpi_in_t random_ray();
    rpi_in_t r;
    logic [31:0] c[12];
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++)
      c[i] = rand_coord(mode < 6 ? 3 : mode < 8 ? 0 : mode < 9 ? 1 : $urandom_range(0, 3));
    r = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
    if ($urandom_range(0, 15) == 0) begin
      // normal perpendicular to direction, plus a tiny tilt
      r.plane_normal_x = -r.ray_dir_y;
      r.plane_normal_y = r.ray_dir_x;
      r.plane_normal_z = $signed($urandom_range(0, 4)) - 2;
    end
    return r;
  endfunction

  function automatic rpi_in_t make_ray(logic [31:0] ox, oy, oz, dx, dy, dz,
                                       px, py, pz, nx, ny, nz);
    return {ox, oy, oz, dx, dy, dz, px, py, pz, nx, ny, nz};
  endfunction

  // whether the offered transaction was taken at the last rising edge
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // Driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_rays.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_rays.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with an optional long hold-off counted here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: predicts on input transactions, checks on output transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) expected_hits.push_back(intersect_ray(in_data));
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          $display("MISMATCH unexpected transaction at %0t", $realtime);
          error_count++;
        end else begin
          rpi_out_t want;
          want = expected_hits.pop_front();
          if (out_data.hit !== want.hit) report_mismatch("hit", out_data.hit, want.hit);
          if (out_data.hit_x !== want.hit_x) report_mismatch("hit_x", out_data.hit_x, want.hit_x);
          if (out_data.hit_y !== want.hit_y) report_mismatch("hit_y", out_data.hit_y, want.hit_y);
          if (out_data.hit_z !== want.hit_z) report_mismatch("hit_z", out_data.hit_z, want.hit_z);
          if (out_data.clipped !== want.clipped)
            report_mismatch("clipped", out_data.clipped, want.clipped);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $realtime);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) pending_rays.push_back(random_ray());
    while (pending_rays.size() > 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    hold_cycles = 0;
    stim_done = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // simple hit: origin at 0, dir +z, plane z = 1
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 32'h10000));
    // zero-length normal, zero-length direction
    pending_rays.push_back(make_ray(5, 6, 7, 1, 2, 3, 9, 9, 9, 0, 0, 0));
    pending_rays.push_back(make_ray(5, 6, 7, 0, 0, 0, 9, 9, 9, 1, 2, 3));
    // exactly parallel, and nearly parallel just around the threshold
    pending_rays.push_back(make_ray(0, 0, 0, 32'h10000, 0, 0, 0, 0, 5, 0, 0, 32'h10000));
    pending_rays.push_back(make_ray(0, 0, 0, 32'h7FFFFFFF, 0, 1, 0, 0, 5, 0, 0, 32'h10000));
    pending_rays.push_back(make_ray(0, 0, 0, 100000, 0, 1, 0, 0, 5, 0, 0, 1));
    pending_rays.push_back(make_ray(0, 0, 0, 99999, 0, 1, 0, 0, 5, 0, 0, 1));
    // overflow both ways, rounding ties
    pending_rays.push_back(make_ray(0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 1,
                                    0, 0, 32'h7FFFFFFF, 0, 0, 1));
    pending_rays.push_back(make_ray(32'h7FFFFFFF, 32'h80000000, 0, 1, 1, 2,
                                    0, 0, 3, 0, 0, 1));
    pending_rays.push_back(make_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                    32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                    32'h80000000, 32'h80000000, 32'h80000000));
    pending_rays.push_back(make_ray(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                    32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    pending_rays.push_back(make_ray(0, 0, 0, 1, 3, -1, 0, 0, 1, 0, 0, 2));
    pending_rays.push_back(make_ray(0, 0, 0, -1, -3, -1, 0, 0, 1, 0, 0, -2));
    pending_rays.push_back(make_ray(1, 1, 1, 1, 1, 1, 0, 0, 0, 1, 1, 1));
    while (pending_rays.size() > 0) @(posedge clk);

    run_phase(0, 0, 300);
    run_phase(63, 0, 250);
    run_phase(0, 63, 250);
    run_phase(27, 27, 200);

    // long output hold-off while rays keep coming, so the input backs up
    hold_cycles = 300;
    run_phase(0, 0, 250);

    stim_done = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 20;
    for (int i = 0; i < 20000 && expected_hits.size() > 0; i++) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (expected_hits.size() > 0) begin
      $display("%0d transactions never arrived", expected_hits.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ ray_plane_intersection_unit.f @@
rtl/core/rpi_pkg.sv
rtl/core/rpi_mulw.sv
rtl/core/rpi_dot.sv
rtl/core/rpi_coord.sv
rtl/core/ray_plane_intersection_unit.sv
tb/ray_plane_intersection_unit_test.sv
